// ===== design/hse_pkg.sv =====
// ============================================================================
// hse_pkg
// Shared types for the heap sort engine: datapath opcodes and status bundle.
// ============================================================================
package hse_pkg;

   localparam int DATA_W = 32;

   // one operation per cycle, issued by the controller to the datapath
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_BUILD_INIT,
      OP_BUILD_RD,
      OP_FETCH,
      OP_EXT_INIT,
      OP_EXT_RD,
      OP_EXT_SWAP,
      OP_SIFT_RD,
      OP_SIFT_PUT,
      OP_SIFT_CMP,
      OP_OUT_INIT,
      OP_OUT_RD,
      OP_OUT_NEXT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } hse_cmd_type;

   typedef struct packed {
      logic idx_zero;   // build loop finished
      logic idx_lt2;    // extract loop finished
      logic leaf;       // sift node has no children
      logic stop;       // sift value dominates larger child
      logic last_out;   // word being shown is the final one
   } hse_status_type;

endpackage

// ===== design/hse_dpath.sv =====
// ============================================================================
// hse_dpath
// Heap store, index counters, sift-down compare and output word register.
// ============================================================================
module hse_dpath #(
   parameter int MAX_LEN = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hse_pkg::hse_cmd_type              cmd,
   input  logic signed [hse_pkg::DATA_W-1:0] req_value,
   output hse_pkg::hse_status_type           status,
   output logic signed [hse_pkg::DATA_W-1:0] rsp_sorted_value
);

   localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW  = $clog2(MAX_LEN + 1);
   localparam int CHW = AW + 2;

   logic signed [hse_pkg::DATA_W-1:0] mem [MAX_LEN];

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] size_ff, size_in;
   logic [AW-1:0] node_ff, node_in;
   logic signed [hse_pkg::DATA_W-1:0] sift_val_ff, sift_val_in;
   logic signed [hse_pkg::DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic right_ok_ff, right_ok_in;

   logic [CW-1:0]  idx_m1;
   logic [CHW-1:0] child_l, child_r;
   logic           full, leaf, right_ok, sel_right, stop;
   logic signed [hse_pkg::DATA_W-1:0] big_val;
   logic [AW-1:0]  big_idx;

   logic                              wr_en, rd_en_a, rd_en_b;
   logic [AW-1:0]                     wr_addr, rd_addr_a, rd_addr_b;
   logic signed [hse_pkg::DATA_W-1:0] wr_data;

   assign idx_m1    = idx_ff - CW'(1);
   assign full      = (count_ff == CW'(MAX_LEN));
   assign child_l   = (CHW'(node_ff) << 1) + CHW'(1);
   assign child_r   = child_l + CHW'(1);
   assign leaf      = (child_l >= CHW'(size_ff));
   assign right_ok  = (child_r < CHW'(size_ff));
   assign sel_right = right_ok_ff && (rd_b_ff > rd_a_ff);
   assign big_val   = sel_right ? rd_b_ff : rd_a_ff;
   assign big_idx   = sel_right ? child_r[AW-1:0] : child_l[AW-1:0];
   assign stop      = (sift_val_ff >= big_val);

   assign status.idx_zero = (idx_ff == '0);
   assign status.idx_lt2  = ((idx_ff >> 1) == '0);
   assign status.leaf     = leaf;
   assign status.stop     = stop;
   assign status.last_out = ((idx_ff + CW'(1)) == count_ff);

   assign rsp_sorted_value = rd_a_ff;

   // memory port control
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = node_ff;
      wr_data   = sift_val_ff;
      rd_en_a   = 1'b0;
      rd_en_b   = 1'b0;
      rd_addr_a = child_l[AW-1:0];
      rd_addr_b = right_ok ? child_r[AW-1:0] : child_l[AW-1:0];
      unique case (cmd.op)
         hse_pkg::OP_LOAD: begin
            wr_en   = !full;
            wr_addr = count_ff[AW-1:0];
            wr_data = req_value;
         end
         hse_pkg::OP_BUILD_RD: begin
            rd_en_a   = 1'b1;
            rd_addr_a = idx_m1[AW-1:0];
         end
         hse_pkg::OP_EXT_RD: begin
            rd_en_a   = 1'b1;
            rd_addr_a = '0;
            rd_en_b   = 1'b1;
            rd_addr_b = idx_m1[AW-1:0];
         end
         hse_pkg::OP_EXT_SWAP: begin
            // old root parks at the end of the shrinking heap
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_a_ff;
         end
         hse_pkg::OP_SIFT_RD: begin
            rd_en_a = 1'b1;
            rd_en_b = 1'b1;
         end
         hse_pkg::OP_SIFT_PUT: begin
            wr_en = 1'b1;
         end
         hse_pkg::OP_SIFT_CMP: begin
            wr_en   = 1'b1;
            wr_data = stop ? sift_val_ff : big_val;
         end
         hse_pkg::OP_OUT_RD: begin
            rd_en_a   = 1'b1;
            rd_addr_a = idx_ff[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   // counters and sift registers
   always_comb begin
      count_in    = count_ff;
      idx_in      = idx_ff;
      size_in     = size_ff;
      node_in     = node_ff;
      sift_val_in = sift_val_ff;
      right_ok_in = right_ok_ff;
      unique case (cmd.op)
         hse_pkg::OP_LOAD:       count_in = full ? count_ff : count_ff + CW'(1);
         hse_pkg::OP_BUILD_INIT: begin
            idx_in  = count_ff >> 1;
            size_in = count_ff;
         end
         hse_pkg::OP_BUILD_RD: begin
            idx_in  = idx_m1;
            node_in = idx_m1[AW-1:0];
         end
         hse_pkg::OP_FETCH:      sift_val_in = rd_a_ff;
         hse_pkg::OP_EXT_INIT:   idx_in = count_ff;
         hse_pkg::OP_EXT_RD: begin
            idx_in  = idx_m1;
            size_in = idx_m1;
            node_in = '0;
         end
         hse_pkg::OP_EXT_SWAP:   sift_val_in = rd_b_ff;
         hse_pkg::OP_SIFT_RD:    right_ok_in = right_ok;
         hse_pkg::OP_SIFT_CMP: begin
            if (!stop) begin
               node_in = big_idx;
            end
         end
         hse_pkg::OP_OUT_INIT:   idx_in = '0;
         hse_pkg::OP_OUT_NEXT: begin
            idx_in = idx_ff + CW'(1);
            if (status.last_out) begin
               count_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      idx_ff      <= idx_in;
      size_ff     <= size_in;
      node_ff     <= node_in;
      sift_val_ff <= sift_val_in;
      right_ok_ff <= right_ok_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_a_ff <= mem[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_b_ff <= mem[rd_addr_b];
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_LEN))
      else $error("item count beyond store depth");

   a_node_in_heap: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == hse_pkg::OP_SIFT_CMP) |-> (CHW'(node_ff) < CHW'(size_ff)))
      else $error("sift node outside heap");
`endif

endmodule

// ===== design/hse_ctrl.sv =====
// ============================================================================
// hse_ctrl
// Sequencer: load, heap build, extract loop, sift-down steps, word output.
// ============================================================================
module hse_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_last,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  hse_pkg::hse_status_type  status,
   output hse_pkg::hse_cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_LOAD,
      S_BUILD_INIT,
      S_BUILD_CHK,
      S_FETCH,
      S_EXT_CHK,
      S_EXT_SWAP,
      S_SIFT_RD,
      S_SIFT_CMP,
      S_OUT_RD,
      S_OUT_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      ext_ff, ext_in;   // sift belongs to extract loop
   state_type loop_chk;

   assign req_ready = (state_ff == S_LOAD);
   assign rsp_valid = (state_ff == S_OUT_WAIT);
   assign loop_chk  = ext_ff ? S_EXT_CHK : S_BUILD_CHK;

   always_comb begin
      state_in = state_ff;
      ext_in   = ext_ff;
      cmd.op   = hse_pkg::OP_NONE;
      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.op = hse_pkg::OP_LOAD;
               if (req_last) begin
                  state_in = S_BUILD_INIT;
               end
            end
         end
         S_BUILD_INIT: begin
            cmd.op   = hse_pkg::OP_BUILD_INIT;
            ext_in   = 1'b0;
            state_in = S_BUILD_CHK;
         end
         S_BUILD_CHK: begin
            if (status.idx_zero) begin
               cmd.op   = hse_pkg::OP_EXT_INIT;
               ext_in   = 1'b1;
               state_in = S_EXT_CHK;
            end else begin
               cmd.op   = hse_pkg::OP_BUILD_RD;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.op   = hse_pkg::OP_FETCH;
            state_in = S_SIFT_RD;
         end
         S_EXT_CHK: begin
            if (status.idx_lt2) begin
               cmd.op   = hse_pkg::OP_OUT_INIT;
               state_in = S_OUT_RD;
            end else begin
               cmd.op   = hse_pkg::OP_EXT_RD;
               state_in = S_EXT_SWAP;
            end
         end
         S_EXT_SWAP: begin
            cmd.op   = hse_pkg::OP_EXT_SWAP;
            state_in = S_SIFT_RD;
         end
         S_SIFT_RD: begin
            if (status.leaf) begin
               cmd.op   = hse_pkg::OP_SIFT_PUT;
               state_in = loop_chk;
            end else begin
               cmd.op   = hse_pkg::OP_SIFT_RD;
               state_in = S_SIFT_CMP;
            end
         end
         S_SIFT_CMP: begin
            cmd.op   = hse_pkg::OP_SIFT_CMP;
            state_in = status.stop ? loop_chk : S_SIFT_RD;
         end
         S_OUT_RD: begin
            cmd.op   = hse_pkg::OP_OUT_RD;
            state_in = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_ready) begin
               cmd.op   = hse_pkg::OP_OUT_NEXT;
               state_in = status.last_out ? S_LOAD : S_OUT_RD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         ext_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ext_ff   <= ext_in;
      end
   end

`ifndef SYNTHESIS
   a_no_load_during_sort: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SIFT_CMP) |-> !req_ready && !rsp_valid)
      else $error("handshake open during sift");
`endif

endmodule

// ===== design/heap_sort_engine_core.sv =====
// ============================================================================
// heap_sort_engine_core
// Binary max-heap sorter for signed 32-bit words, ascending output.
// ============================================================================
// Load words one per cycle on the req channel; the word with req_last set
// closes the set. Up to MAX_LEN words are kept; further words are taken and
// dropped. After the last word req_ready stays low while the heap is built
// and drained in the store, then every kept word comes out on the rsp channel
// smallest first, duplicates kept, rsp_last_out on the largest. req_ready
// rises again the cycle after the final word is taken.
// Each sift-down level reads both children from the store, then compares
// and writes back; each output word is read from the store, then held
// until taken. The store has one write port and two registered read ports,
// which is why a sift level is split into a read step and a compare step.
module heap_sort_engine_core #(
   parameter int MAX_LEN = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [hse_pkg::DATA_W-1:0] req_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [hse_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                              rsp_last_out
);

   hse_pkg::hse_cmd_type    cmd;
   hse_pkg::hse_status_type status;

   // sequencer: issues one datapath op per cycle
   hse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // store, counters and compare logic
   hse_dpath #(
      .MAX_LEN (MAX_LEN)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_value        (req_value),
      .status           (status),
      .rsp_sorted_value (rsp_sorted_value)
   );

   // last flag is only meaningful while a word is shown
   assign rsp_last_out = status.last_out;

`ifndef SYNTHESIS
   a_one_side_open: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("load and output open together");

   a_reload_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_out) |=> req_ready)
      else $error("not ready for a new set after final word");
`endif

endmodule
